>>> rtl/jsu_pkg.sv
// Shared types and constants of the JSON string unescaper.
package jsu_pkg;

  // Decoder phase.
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX1 = 3'd3,
    PH_HEX2 = 3'd4,
    PH_HEX3 = 3'd5,
    PH_HEX4 = 3'd6
  } phase_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOQUOTE = 3'd1,
    ST_CTRL    = 3'd2,
    ST_ESC     = 3'd3,
    ST_HEX     = 3'd4,
    ST_SURR    = 3'd5,
    ST_UNTERM  = 3'd6
  } status_t;

  // Characters that the decoder looks for.
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B = 8'h62;
  localparam logic [7:0] CH_F = 8'h66;
  localparam logic [7:0] CH_N = 8'h6e;
  localparam logic [7:0] CH_R = 8'h72;
  localparam logic [7:0] CH_T = 8'h74;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // One result word, without its last marker.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       done_res;
    status_t    status;
  } res_t;

  // All results that one input byte causes.
  typedef struct packed {
    logic [1:0]      cnt;
    res_t [2:0]      r;
  } bundle_t;

  function automatic res_t mk_res(logic [7:0] b, logic v, logic d, status_t s);
    res_t x;
    x.out_byte   = b;
    x.byte_valid = v;
    x.done_res   = d;
    x.status     = s;
    return x;
  endfunction

endpackage

>>> rtl/json_string_unescape.sv
// A byte passes the input register and is decoded into the result register, which offers its words.
// Throughput: one input byte per cycle while m_tready is high; a \u escape that encodes to two
// or three UTF-8 bytes holds the input while the result register drains.
// Bytes that give no result (opening quote, backslash, u, the first three hex digits) do not hold the input.
// Reset (rst, synchronous, active high) empties the registers and waits for an opening quote.
module json_string_unescape import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // in_byte[7:0]
  input  logic        s_tlast,   // end_of_input
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_byte[7:0], done_res[8], status[11:9], zero[15:12]
  output logic        m_tuser,   // byte_valid
  output logic        m_tlast    // last
);

  logic       in_v;
  logic [7:0] in_byte;
  logic       in_eoi;
  logic       load_ok;
  logic       adv;
  bundle_t    bundle;

  assign adv      = in_v && load_ok;
  assign s_tready = !in_v || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_v <= 1'b1;
    end else if (adv) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_eoi  <= s_tlast;
    end
  end

  jsu_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .go      (adv),
    .in_byte (in_byte),
    .in_eoi  (in_eoi),
    .bundle  (bundle)
  );

  jsu_serial u_serial (
    .clk      (clk),
    .rst      (rst),
    .load     (adv),
    .bundle   (bundle),
    .load_ok  (load_ok),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> rtl/jsu_decode.sv
// Decoder state and the logic that turns one byte into a bundle of results.
module jsu_decode import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  logic [7:0] in_byte,
  input  logic       in_eoi,
  output bundle_t    bundle
);

  phase_t      phase, phase_next;
  logic [11:0] accum, accum_next;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] cp;
  logic [7:0]  esc_byte;

  // Hex digit value, either case.
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = 4'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_val = 4'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_val = 4'(in_byte - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp = {accum, hex_val};

  // Main decode of the current byte.
  always_comb begin
    phase_next = phase;
    accum_next = accum;
    bundle     = '0;
    esc_byte   = 8'd0;
    case (phase)
      PH_STR: begin
        if (in_byte == CH_QUOTE) begin
          phase_next = PH_IDLE;
          bundle.cnt = 2'd1;
          bundle.r[0] = mk_res(8'd0, 1'b0, 1'b1, ST_OK);
        end else if (in_byte == CH_BSLASH) begin
          phase_next = PH_ESC;
        end else if (in_byte < CH_SPACE) begin
          phase_next = PH_IDLE;
          accum_next = '0;
          bundle.cnt = 2'd1;
          bundle.r[0] = mk_res(8'd0, 1'b0, 1'b0, ST_CTRL);
        end else begin
          bundle.cnt = 2'd1;
          bundle.r[0] = mk_res(in_byte, 1'b1, 1'b0, ST_OK);
        end
      end
      PH_ESC: begin
        case (in_byte)
          CH_QUOTE, CH_BSLASH, CH_SLASH: esc_byte = in_byte;
          CH_B: esc_byte = 8'd8;
          CH_F: esc_byte = 8'd12;
          CH_N: esc_byte = 8'd10;
          CH_R: esc_byte = 8'd13;
          CH_T: esc_byte = 8'd9;
          default: esc_byte = 8'd0;
        endcase
        case (in_byte)
          CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T: begin
            phase_next = PH_STR;
            bundle.cnt = 2'd1;
            bundle.r[0] = mk_res(esc_byte, 1'b1, 1'b0, ST_OK);
          end
          CH_U: begin
            phase_next = PH_HEX1;
            accum_next = '0;
          end
          default: begin
            phase_next = PH_IDLE;
            accum_next = '0;
            bundle.cnt = 2'd1;
            bundle.r[0] = mk_res(8'd0, 1'b0, 1'b0, ST_ESC);
          end
        endcase
      end
      PH_HEX1, PH_HEX2, PH_HEX3: begin
        if (!hex_ok) begin
          phase_next = PH_IDLE;
          accum_next = '0;
          bundle.cnt = 2'd1;
          bundle.r[0] = mk_res(8'd0, 1'b0, 1'b0, ST_HEX);
        end else begin
          accum_next = {accum[7:0], hex_val};
          phase_next = phase_t'(phase + 3'd1);
        end
      end
      PH_HEX4: begin
        accum_next = '0;
        if (!hex_ok) begin
          phase_next = PH_IDLE;
          bundle.cnt = 2'd1;
          bundle.r[0] = mk_res(8'd0, 1'b0, 1'b0, ST_HEX);
        end else if (cp[15:11] == 5'b11011) begin
          phase_next = PH_IDLE;
          bundle.cnt = 2'd1;
          bundle.r[0] = mk_res(8'd0, 1'b0, 1'b0, ST_SURR);
        end else begin
          phase_next = PH_STR;
          if (cp[15:7] == '0) begin
            bundle.cnt = 2'd1;
            bundle.r[0] = mk_res(cp[7:0], 1'b1, 1'b0, ST_OK);
          end else if (cp[15:11] == '0) begin
            bundle.cnt = 2'd2;
            bundle.r[0] = mk_res({3'b110, cp[10:6]}, 1'b1, 1'b0, ST_OK);
            bundle.r[1] = mk_res({2'b10, cp[5:0]}, 1'b1, 1'b0, ST_OK);
          end else begin
            bundle.cnt = 2'd3;
            bundle.r[0] = mk_res({4'b1110, cp[15:12]}, 1'b1, 1'b0, ST_OK);
            bundle.r[1] = mk_res({2'b10, cp[11:6]}, 1'b1, 1'b0, ST_OK);
            bundle.r[2] = mk_res({2'b10, cp[5:0]}, 1'b1, 1'b0, ST_OK);
          end
        end
      end
      default: begin
        // Idle: only an opening quote starts a string.
        if (in_byte == CH_QUOTE) begin
          phase_next = PH_STR;
          accum_next = '0;
        end else begin
          phase_next = PH_IDLE;
          bundle.cnt = 2'd1;
          bundle.r[0] = mk_res(8'd0, 1'b0, 1'b0, ST_NOQUOTE);
        end
      end
    endcase

    // Input ran out inside a string: mark the final result unterminated.
    if (in_eoi && phase_next != PH_IDLE) begin
      phase_next = PH_IDLE;
      accum_next = '0;
      case (bundle.cnt)
        2'd1: bundle.r[0].status = ST_UNTERM;
        2'd2: bundle.r[1].status = ST_UNTERM;
        2'd3: bundle.r[2].status = ST_UNTERM;
        default: begin
          bundle.cnt = 2'd1;
          bundle.r[0] = mk_res(8'd0, 1'b0, 1'b0, ST_UNTERM);
        end
      endcase
    end
  end

  // State registers advance once per decoded byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      accum <= '0;
    end else if (go) begin
      phase <= phase_next;
      accum <= accum_next;
    end
  end

`ifndef ASSERT_OFF
  a_eoi_idle: assert property (@(posedge clk) disable iff (rst)
    go && in_eoi |=> phase == PH_IDLE)
    else $error("decoder not idle after end of input");
  a_three_valid: assert property (@(posedge clk) disable iff (rst)
    bundle.cnt == 2'd3 |-> bundle.r[0].byte_valid && bundle.r[1].byte_valid &&
                          bundle.r[2].byte_valid)
    else $error("three-word bundle with a non-data word");
`endif

endmodule

>>> rtl/jsu_serial.sv
// Result register that hands out a bundle one word per cycle while m_tready is high.
module jsu_serial import jsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  bundle_t     bundle,
  output logic        load_ok,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  output logic        m_tuser,
  output logic        m_tlast
);

  logic [1:0]  cnt;
  logic [1:0]  idx;
  res_t [2:0]  r;
  res_t        cur;
  logic        out_acc;

  // Pick the word that is on offer.
  always_comb begin
    case (idx)
      2'd0: cur = r[0];
      2'd1: cur = r[1];
      default: cur = r[2];
    endcase
  end

  assign m_tvalid = (cnt != 2'd0);
  assign m_tlast  = (idx == 2'(cnt - 2'd1));
  assign m_tdata  = {4'd0, cur.status, cur.done_res, cur.out_byte};
  assign m_tuser  = cur.byte_valid;
  assign out_acc  = m_tvalid && m_tready;
  assign load_ok  = (cnt == 2'd0) || (out_acc && m_tlast);

  // Bundle register: load a new bundle or step through the held one.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      idx <= 2'd0;
    end else if (load) begin
      cnt <= bundle.cnt;
      idx <= 2'd0;
    end else if (out_acc) begin
      if (m_tlast) begin
        cnt <= 2'd0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      r <= bundle.r;
    end
  end

`ifndef ASSERT_OFF
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> idx < cnt)
    else $error("word index beyond bundle");
  a_keep_going: assert property (@(posedge clk) disable iff (rst)
    out_acc && !m_tlast |=> m_tvalid)
    else $error("bundle dropped before its last word");
`endif

endmodule
